>>> rtl/core/hpv_pkg.sv
// Shared types, constants and character classes for the host/port validator.
package hpv_pkg;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_HYPHEN = 8'h2D;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_COLON  = 8'h3A;

  localparam logic [5:0] MAX_LABEL_RST = 6'd63;
  localparam logic [7:0] MAX_NAME_RST  = 8'd253;

  localparam logic CFG_MAX_LABEL = 1'b0;
  localparam logic CFG_MAX_NAME  = 1'b1;

  typedef enum logic [3:0] {
    PH_NAME        = 4'b0001,
    PH_PORT_FIRST  = 4'b0010,
    PH_PORT_DIGITS = 4'b0100,
    PH_PORT_TAIL   = 4'b1000
  } phase_e;

  typedef struct packed {
    phase_e      phase;
    logic [5:0]  label_cnt;
    logic [7:0]  name_cnt;
    logic [15:0] port;
    logic        failed;
  } state_t;

  typedef struct packed {
    logic        valid_res;
    logic [7:0]  name_length;
    logic [15:0] port_number;
  } result_t;

  localparam state_t STATE_RESET = '{
    phase:     PH_NAME,
    label_cnt: 6'd0,
    name_cnt:  8'd0,
    port:      16'd0,
    failed:    1'b0
  };

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_name_char(input logic [7:0] c);
    return ((c >= 8'h61) && (c <= 8'h7A)) ||
           ((c >= 8'h41) && (c <= 8'h5A)) ||
           is_digit(c) || (c == CH_HYPHEN);
  endfunction

endpackage

>>> rtl/core/hpv_step.sv
// Next-state and result logic for one byte of the host string.
module hpv_step (
  input  hpv_pkg::state_t  cur_i,
  input  logic [7:0]       char_i,
  input  logic [5:0]       max_label_i,
  input  logic [7:0]       max_name_i,
  output hpv_pkg::state_t  nxt_o,
  output logic             emit_o,
  output hpv_pkg::result_t res_o
);

  logic ok;
  logic forced;
  logic label_full;

  assign forced     = cur_i.name_cnt >= max_name_i;
  assign label_full = ({1'b0, cur_i.label_cnt} + 7'd1) > {1'b0, max_label_i};
  assign ok         = !cur_i.failed && (cur_i.phase != hpv_pkg::PH_PORT_FIRST);

  always_comb begin
    nxt_o  = cur_i;
    emit_o = 1'b0;
    res_o  = '0;
    if (char_i == hpv_pkg::CH_NUL) begin
      emit_o            = 1'b1;
      res_o.valid_res   = ok;
      res_o.name_length = ok ? cur_i.name_cnt : 8'd0;
      res_o.port_number = ok ? cur_i.port : 16'd0;
      nxt_o             = hpv_pkg::STATE_RESET;
    end else if (!cur_i.failed) begin
      unique case (cur_i.phase)
        hpv_pkg::PH_NAME: begin
          if (!forced && char_i == hpv_pkg::CH_DOT) begin
            if (cur_i.label_cnt == 6'd0) begin
              nxt_o.failed = 1'b1;
            end else begin
              nxt_o.label_cnt = 6'd0;
              nxt_o.name_cnt  = cur_i.name_cnt + 8'd1;
            end
          end else if (!forced && hpv_pkg::is_name_char(char_i)) begin
            if (label_full) begin
              nxt_o.failed = 1'b1;
            end else begin
              nxt_o.label_cnt = cur_i.label_cnt + 6'd1;
              nxt_o.name_cnt  = cur_i.name_cnt + 8'd1;
            end
          end else if (char_i == hpv_pkg::CH_COLON) begin
            nxt_o.phase = hpv_pkg::PH_PORT_FIRST;
          end else begin
            nxt_o.failed = 1'b1;
          end
        end
        hpv_pkg::PH_PORT_FIRST: begin
          if (hpv_pkg::is_digit(char_i)) begin
            nxt_o.port  = {12'd0, char_i[3:0]};
            nxt_o.phase = hpv_pkg::PH_PORT_DIGITS;
          end else begin
            nxt_o.failed = 1'b1;
          end
        end
        hpv_pkg::PH_PORT_DIGITS: begin
          if (hpv_pkg::is_digit(char_i)) begin
            // port * 10 + digit, wraps at 16 bits
            nxt_o.port = {cur_i.port[12:0], 3'b000} + {cur_i.port[14:0], 1'b0}
                       + {12'd0, char_i[3:0]};
          end else begin
            nxt_o.phase = hpv_pkg::PH_PORT_TAIL;
          end
        end
        hpv_pkg::PH_PORT_TAIL: begin
          nxt_o = cur_i;
        end
        default: begin
          nxt_o = cur_i;
        end
      endcase
    end
  end

endmodule

>>> rtl/core/hostname_port_validator.sv
// Top level of the host/port validator: config, input, state and result registers.
// Bytes of a host string enter one per cycle. Each accepted byte sits in the input
// register until it is applied to the parse state; only the stall below delays that.
// The zero byte that ends a string passes through the input register; when it is
// applied, the same edge loads one result (valid flag, name length, port) into the
// output register and out_valid_o rises. One byte per cycle is sustained. The input
// stalls only while a zero byte in the input register finds the output register
// holding a result that is not taken in that cycle; the bytes behind it wait with it.
module hostname_port_validator (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [7:0]  cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  character_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        valid_res_o,
  output logic [7:0]  name_length_o,
  output logic [15:0] port_number_o
);

  logic [5:0]       max_label_q;
  logic [7:0]       max_name_q;
  logic             in_vld_q, in_vld_d;
  logic [7:0]       char_q;
  hpv_pkg::state_t  state_q, state_d;
  logic             out_vld_q, out_vld_d;
  hpv_pkg::result_t res_q, res_d;
  logic             emit;
  logic             adv;
  logic             in_acc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_label_q <= hpv_pkg::MAX_LABEL_RST;
      max_name_q  <= hpv_pkg::MAX_NAME_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        hpv_pkg::CFG_MAX_LABEL: max_label_q <= cfg_data_i[5:0];
        hpv_pkg::CFG_MAX_NAME:  max_name_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  hpv_step u_step (
    .cur_i       (state_q),
    .char_i      (char_q),
    .max_label_i (max_label_q),
    .max_name_i  (max_name_q),
    .nxt_o       (state_d),
    .emit_o      (emit),
    .res_o       (res_d)
  );

  assign adv        = in_vld_q && (!emit || !out_vld_q || out_ready_i);
  assign in_ready_o = !in_vld_q || adv;
  assign in_acc     = in_valid_i && in_ready_o;
  assign in_vld_d   = in_ready_o ? in_valid_i : in_vld_q;
  assign out_vld_d  = (adv && emit) ? 1'b1 : (out_ready_i ? 1'b0 : out_vld_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      state_q   <= hpv_pkg::STATE_RESET;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
      if (adv) begin
        state_q <= state_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      char_q <= character_i;
    end
    if (adv && emit) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o   = out_vld_q;
  assign valid_res_o   = res_q.valid_res;
  assign name_length_o = res_q.name_length;
  assign port_number_o = res_q.port_number;

  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && !res_q.valid_res |-> res_q.name_length == 8'd0 && res_q.port_number == 16'd0)
    else $error("rejected string carries nonzero length or port");

  a_clear_after_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && emit |=> state_q == hpv_pkg::STATE_RESET)
    else $error("parse state not cleared after end of string");

  a_byte_no_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_vld_q && (char_q != hpv_pkg::CH_NUL) |-> in_ready_o)
    else $error("ordinary byte stalled the input");

  a_emit_loads_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && emit |=> out_vld_q)
    else $error("end of string did not load a result");

endmodule
